// File: rtl/core/assert_macros.svh
// Assertion helper macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define HEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define HEQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/core/heq_pkg.sv
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Shared types, constants and sizes of the histogram equalizer.
// ----------------------------------------------------------------------------
package heq_pkg;
  localparam int MAX_PIXELS = 65536;
  localparam int CHANNELS   = 3;
  localparam int NBINS      = 256;
  localparam int CW         = 17;
  localparam int BW         = 8;
  localparam int TW         = 19;
  localparam int NW         = 27;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);
  localparam logic [BW-1:0] MAXVAL  = 8'd255;

  typedef enum logic [0:0] {
    OP_ACC = 1'b0,
    OP_MAP = 1'b1
  } op_t;

  localparam logic [1:0] REG_POOLED = 2'd0;
  localparam logic [1:0] REG_CHCNT  = 2'd1;

  typedef struct packed {
    logic          rd_en;
    logic [BW-1:0] rd_addr;
    logic          wr_en;
    logic [BW-1:0] wr_addr;
  } lane_ctl_t;
endpackage

// File: rtl/core/heq_if.sv
// ----------------------------------------------------------------------------
// Histogram equalizer channels
// Valid/ready channel interfaces for pixel beats and result beats.
// ----------------------------------------------------------------------------
interface heq_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       operation;
  logic       last;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  modport source (output valid, operation, last, chan_a, chan_b, chan_c, input ready);
  modport sink (input valid, operation, last, chan_a, chan_b, chan_c, output ready);
endinterface

interface heq_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] out_a;
  logic [7:0] out_b;
  logic [7:0] out_c;
  logic       status;
  logic       pass_end;
  modport source (output valid, out_a, out_b, out_c, status, pass_end, input ready);
  modport sink (input valid, out_a, out_b, out_c, status, pass_end, output ready);
endinterface

// File: rtl/core/heq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: rtl/core/heq_lane.sv
// ----------------------------------------------------------------------------
// Histogram lane
// One channel's 256-bin histogram memory; the read-modify-write datapath is in the top level.
// ----------------------------------------------------------------------------
module heq_lane (
  input  logic                     clk,
  input  heq_pkg::lane_ctl_t       ctl,
  input  logic [heq_pkg::CW-1:0]   wr_data,
  output logic [heq_pkg::CW-1:0]   rd_data
);
  heq_ram #(.WIDTH(heq_pkg::CW), .DEPTH(heq_pkg::NBINS)) u_ram (
    .clk    (clk),
    .wr_en  (ctl.wr_en),
    .wr_addr(ctl.wr_addr),
    .wr_data(wr_data),
    .rd_en  (ctl.rd_en),
    .rd_addr(ctl.rd_addr),
    .rd_data(rd_data)
  );
endmodule

// File: rtl/core/heq_div.sv
// ----------------------------------------------------------------------------
// Rounding divider
// Restoring divider giving round-half-even of num/den, saturated to 255, one bit per cycle.
// ----------------------------------------------------------------------------
module heq_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [heq_pkg::NW-1:0] num,
  input  logic [heq_pkg::TW-1:0] den,
  output logic                   done,
  output logic [heq_pkg::BW-1:0] quot
);
  localparam int CNTW = $clog2(heq_pkg::NW + 1);
  logic [heq_pkg::NW-1:0] q_r, q_nxt;
  logic [heq_pkg::TW:0]   rem_r, rem_nxt;
  logic [heq_pkg::TW-1:0] den_r, den_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [heq_pkg::TW:0]   sh;
  logic [heq_pkg::TW+1:0] twice;
  logic                   up;
  logic [heq_pkg::NW:0]   qr;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[heq_pkg::TW-1:0], q_r[heq_pkg::NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNTW'(heq_pkg::NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[heq_pkg::NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[heq_pkg::NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign twice = {rem_r, 1'b0};
  assign up    = (twice > {2'b0, den_r}) || ((twice == {2'b0, den_r}) && q_r[0]);
  assign qr    = {1'b0, q_r} + {{heq_pkg::NW{1'b0}}, up};
  assign quot  = (qr > (heq_pkg::NW+1)'(heq_pkg::MAXVAL)) ? heq_pkg::MAXVAL : qr[heq_pkg::BW-1:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end
endmodule

// File: rtl/core/histogram_equalizer_top.sv
// Accumulate beats: each is a read, an update and a write back per lane.
// Last accumulate beat: a 256-step prefix walk in all lanes.
// Map beats: each used channel goes in turn through the shared rounding divider.
// Last map beat: a clearing walk of all 256 bins in all lanes; no beat is taken meanwhile.
// Reset is synchronous and active low; it starts the same clearing walk.
// ----------------------------------------------------------------------------
// Histogram equalizer top level
// Three histogram lanes, a pooled-sum merge stage and a shared divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module histogram_equalizer_top (
  input  logic        clk,
  input  logic        rst_n,
  heq_in_if.sink      in_ch,
  heq_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int C  = heq_pkg::CHANNELS;
  localparam int CW = heq_pkg::CW;
  localparam int BW = heq_pkg::BW;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ARD   = 9'b000000100,
    S_AWR   = 9'b000001000,
    S_PFX   = 9'b000010000,
    S_MRD   = 9'b000100000,
    S_MSUM  = 9'b001000000,
    S_MDIV  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 pooled_r;
  logic [1:0]           chcnt_r;
  logic [1:0]           nch;
  logic [CW-1:0]        total_r, total_nxt;
  logic                 cready_r, cready_nxt;
  logic [BW:0]          idx_r, idx_nxt;
  logic [1:0]           ch_r, ch_nxt;
  logic                 last_r, last_nxt;
  logic [BW-1:0]        v_r [C];
  logic [BW-1:0]        v_nxt [C];
  logic [CW-1:0]        acc_r [C];
  logic [CW-1:0]        acc_nxt [C];
  logic [BW-1:0]        res_r [C];
  logic [BW-1:0]        res_nxt [C];
  logic                 status_r, status_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic                 obusy_r, obusy_nxt;
  logic                 cnt_ok_r, cnt_ok_nxt;
  heq_pkg::lane_ctl_t   ctl [C];
  logic [CW-1:0]        wdata [C];
  logic [CW-1:0]        rdata [C];
  logic [CW+1:0]        cdf_sum_r, cdf_sum_nxt;
  logic                 div_start;
  logic                 div_done;
  logic [BW-1:0]        div_q;
  logic [heq_pkg::TW-1:0] den;
  logic [heq_pkg::NW-1:0] num;
  logic                 in_acc;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pooled_r <= 1'b0;
      chcnt_r  <= 2'd3;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == heq_pkg::REG_POOLED[0]) begin
        pooled_r <= cfg_pwdata[0];
      end else begin
        chcnt_r <= cfg_pwdata[1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == heq_pkg::REG_CHCNT[0]) begin
      cfg_prdata[1:0] = chcnt_r;
    end else begin
      cfg_prdata[0] = pooled_r;
    end
  end

  assign nch = (chcnt_r == 2'd0) ? 2'd1 : chcnt_r;

  for (genvar g = 0; g < C; g++) begin : g_lane
    heq_lane u_lane (
      .clk    (clk),
      .ctl    (ctl[g]),
      .wr_data(wdata[g]),
      .rd_data(rdata[g])
    );
  end

  assign den = pooled_r ? heq_pkg::TW'(total_r) * heq_pkg::TW'(nch) : heq_pkg::TW'(total_r);
  assign num = heq_pkg::NW'(cdf_sum_r) * heq_pkg::NW'(heq_pkg::MAXVAL);

  heq_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (div_q)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !obusy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    cready_nxt  = cready_r;
    idx_nxt     = idx_r;
    ch_nxt      = ch_r;
    last_nxt    = last_r;
    status_nxt  = status_r;
    ovalid_nxt  = ovalid_r;
    obusy_nxt   = obusy_r;
    cnt_ok_nxt  = cnt_ok_r;
    cdf_sum_nxt = cdf_sum_r;
    div_start   = 1'b0;
    for (int i = 0; i < C; i++) begin
      v_nxt[i]     = v_r[i];
      acc_nxt[i]   = acc_r[i];
      res_nxt[i]   = res_r[i];
      ctl[i]       = '0;
      wdata[i]     = '0;
    end
    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
      obusy_nxt  = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        for (int i = 0; i < C; i++) begin
          ctl[i].wr_en   = 1'b1;
          ctl[i].wr_addr = idx_r[BW-1:0];
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r[BW-1:0] == heq_pkg::MAXVAL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          v_nxt[0] = in_ch.chan_a;
          v_nxt[1] = in_ch.chan_b;
          v_nxt[2] = in_ch.chan_c;
          last_nxt = in_ch.last;
          if (in_ch.operation == heq_pkg::OP_ACC) begin
            if (!cready_r) begin
              cnt_ok_nxt = total_r < heq_pkg::MAX_CNT;
              for (int i = 0; i < C; i++) begin
                ctl[i].rd_en   = 1'b1;
                ctl[i].rd_addr = (i == 0) ? in_ch.chan_a :
                                 (i == 1) ? in_ch.chan_b : in_ch.chan_c;
              end
              state_nxt = S_ARD;
            end
          end else begin
            for (int i = 0; i < C; i++) begin
              res_nxt[i] = '0;
            end
            obusy_nxt = 1'b1;
            if (!cready_r || total_r == '0) begin
              status_nxt = 1'b1;
              state_nxt  = S_OUT;
            end else begin
              status_nxt = 1'b0;
              ch_nxt     = '0;
              idx_nxt    = '0;
              state_nxt  = S_MRD;
            end
          end
        end
      end
      S_ARD: begin
        state_nxt = S_AWR;
      end
      S_AWR: begin
        if (cnt_ok_r) begin
          for (int i = 0; i < C; i++) begin
            ctl[i].wr_en   = (2'(i) < nch);
            ctl[i].wr_addr = v_r[i];
            wdata[i]       = rdata[i] + 1'b1;
          end
          total_nxt = total_r + 1'b1;
        end
        if (last_r) begin
          idx_nxt = '0;
          for (int i = 0; i < C; i++) begin
            acc_nxt[i] = '0;
          end
          state_nxt = S_PFX;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PFX: begin
        // Reads run one step ahead of the running-sum write-back.
        for (int i = 0; i < C; i++) begin
          ctl[i].rd_en   = 1'b1;
          ctl[i].rd_addr = idx_r[BW-1:0];
          if (idx_r != '0) begin
            ctl[i].wr_en   = 1'b1;
            ctl[i].wr_addr = idx_r[BW-1:0] - 1'b1;
            wdata[i]       = acc_r[i] + rdata[i];
            acc_nxt[i]     = acc_r[i] + rdata[i];
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (BW+1)'(heq_pkg::NBINS)) begin
          cready_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MRD: begin
        for (int i = 0; i < C; i++) begin
          ctl[i].rd_en   = 1'b1;
          ctl[i].rd_addr = pooled_r ? v_r[ch_r] : v_r[i];
        end
        state_nxt = S_MSUM;
      end
      S_MSUM: begin
        if (pooled_r) begin
          cdf_sum_nxt = {2'b0, rdata[0]}
                      + ((nch > 2'd1) ? {2'b0, rdata[1]} : '0)
                      + ((nch > 2'd2) ? {2'b0, rdata[2]} : '0);
        end else begin
          cdf_sum_nxt = {2'b0, rdata[ch_r]};
        end
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        if (!div_done && (cdf_sum_r != '1)) begin
          div_start = (idx_r == '0);
          idx_nxt   = '1;
        end
        if (div_done) begin
          res_nxt[ch_r] = div_q;
          idx_nxt       = '0;
          if (ch_r + 2'd1 >= nch) begin
            state_nxt = S_OUT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_MRD;
          end
        end
      end
      S_OUT: begin
        ovalid_nxt = 1'b1;
        if (last_r) begin
          total_nxt  = '0;
          cready_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_CLEAR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      total_r  <= '0;
      cready_r <= 1'b0;
      idx_r    <= '0;
      ch_r     <= '0;
      ovalid_r <= 1'b0;
      obusy_r  <= 1'b0;
      cnt_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      cready_r <= cready_nxt;
      idx_r    <= idx_nxt;
      ch_r     <= ch_nxt;
      ovalid_r <= ovalid_nxt;
      obusy_r  <= obusy_nxt;
      cnt_ok_r <= cnt_ok_nxt;
    end
    last_r    <= last_nxt;
    status_r  <= status_nxt;
    cdf_sum_r <= cdf_sum_nxt;
    for (int i = 0; i < C; i++) begin
      v_r[i]   <= v_nxt[i];
      acc_r[i] <= acc_nxt[i];
      res_r[i] <= res_nxt[i];
    end
  end

  assign out_ch.valid    = ovalid_r;
  assign out_ch.out_a    = res_r[0];
  assign out_ch.out_b    = res_r[1];
  assign out_ch.out_c    = res_r[2];
  assign out_ch.status   = status_r;
  assign out_ch.pass_end = last_r;

  `HEQ_ASSERT_IMP(a_no_take_busy, clk, rst_n, in_ch.ready, !ovalid_r, "beat taken while busy")
  `HEQ_ASSERT_IMP(a_total_cap, clk, rst_n, 1'b1, total_r <= heq_pkg::MAX_CNT, "total over cap")
  `HEQ_ASSERT_NXT(a_hold, clk, rst_n, ovalid_r && !out_ch.ready, ovalid_r, "result dropped")
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram equalizer testbench
// Streams accumulate and map passes into the equalizer under several channel
// and pooling settings, predicts every equalized pixel, and compares each
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    heq_pkg::op_t op;
    logic         last;
    logic [7:0]   a;
    logic [7:0]   b;
    logic [7:0]   c;
  } pixel_t;

  typedef struct {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       status;
    logic       pass_end;
  } eq_pixel_t;

  localparam int SETTLE_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  heq_in_if  in_ch (clk);
  heq_out_if out_ch (clk);

  histogram_equalizer_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  int unsigned hist_bins [heq_pkg::CHANNELS*heq_pkg::NBINS];
  int unsigned pixel_count;
  bit          hist_closed;
  bit          pooled_sel;
  logic [1:0]  chan_sel;

  pixel_t    pixel_q [$];
  eq_pixel_t eq_q [$];
  pixel_t    cur_pixel;
  int        pushed_n;
  int        accepted_n;
  int        errors;
  int        gap_left;
  int        stall_left;
  int        hold_left;
  bit        hold_req;
  bit        no_idle;
  longint    cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int used_chans();
    if (chan_sel == 2'd0) return 1;
    if (chan_sel > heq_pkg::CHANNELS) return heq_pkg::CHANNELS;
    return int'(chan_sel);
  endfunction

  function automatic logic [7:0] equalize(longint unsigned cdf, longint unsigned tot);
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    num = 255 * cdf;
    q = num / tot;
    r = num % tot;
    if (2 * r > tot || (2 * r == tot && q[0])) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  task automatic clear_hist();
    foreach (hist_bins[i]) hist_bins[i] = 0;
    pixel_count = 0;
    hist_closed = 0;
  endtask

  task automatic apply_pixel(pixel_t p);
    int n;
    logic [7:0] v [3];
    logic [7:0] res [3];
    longint unsigned cdf;
    longint unsigned tot;
    eq_pixel_t e;
    n = used_chans();
    v[0] = p.a;
    v[1] = p.b;
    v[2] = p.c;
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    if (p.op == heq_pkg::OP_ACC) begin
      if (hist_closed) return;
      if (pixel_count < heq_pkg::MAX_PIXELS) begin
        for (int ch = 0; ch < n; ch++) hist_bins[ch*heq_pkg::NBINS + v[ch]]++;
        pixel_count++;
      end
      if (p.last) begin
        for (int ch = 0; ch < heq_pkg::CHANNELS; ch++)
          for (int k = 1; k < heq_pkg::NBINS; k++)
            hist_bins[ch*heq_pkg::NBINS + k] += hist_bins[ch*heq_pkg::NBINS + k - 1];
        hist_closed = 1;
      end
      return;
    end
    e.pass_end = p.last;
    if (!hist_closed || pixel_count == 0) begin
      e.status = 1'b1;
    end else begin
      e.status = 1'b0;
      for (int ch = 0; ch < n; ch++) begin
        cdf = 0;
        if (pooled_sel) begin
          for (int k = 0; k < n; k++) cdf += hist_bins[k*heq_pkg::NBINS + v[ch]];
          tot = longint'(n) * pixel_count;
        end else begin
          cdf = hist_bins[ch*heq_pkg::NBINS + v[ch]];
          tot = pixel_count;
        end
        res[ch] = equalize(cdf, tot);
      end
    end
    e.a = res[0];
    e.b = res[1];
    e.c = res[2];
    eq_q = {eq_q, e};
    if (p.last) clear_hist();
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d, wanted %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Input side: one beat per handshake, fed from the pending pixel queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_pixel(cur_pixel);
        accepted_n++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          cur_pixel = pixel_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= cur_pixel.op;
          in_ch.last <= cur_pixel.last;
          in_ch.chan_a <= cur_pixel.a;
          in_ch.chan_b <= cur_pixel.b;
          in_ch.chan_c <= cur_pixel.c;
          gap_left <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (eq_q.size() == 0) begin
          report("unexpected result beat", 0, 0);
        end else begin
          eq_pixel_t e;
          e = eq_q.pop_front();
          if (out_ch.out_a !== e.a) report("out_a", out_ch.out_a, e.a);
          if (out_ch.out_b !== e.b) report("out_b", out_ch.out_b, e.b);
          if (out_ch.out_c !== e.c) report("out_c", out_ch.out_c, e.c);
          if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
          if (out_ch.pass_end !== e.pass_end)
            report("pass_end", out_ch.pass_end, e.pass_end);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_left <= 800;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_pixel(heq_pkg::op_t op, logic last, logic [7:0] a, logic [7:0] b,
                            logic [7:0] c);
    pixel_t p;
    p.op = op;
    p.last = last;
    p.a = a;
    p.b = b;
    p.c = c;
    pixel_q = {pixel_q, p};
    pushed_n++;
  endtask

  function automatic logic [7:0] rand_level();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 7) * 36);
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_random(heq_pkg::op_t op, logic last);
    push_pixel(op, last, rand_level(), rand_level(), rand_level());
  endtask

  task automatic wait_idle();
    wait (accepted_n == pushed_n && eq_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 1'b0} << 1;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == heq_pkg::REG_POOLED) pooled_sel = value[0];
    else chan_sel = value[1:0];
  endtask

  task automatic random_pass(int nacc, int nmap);
    if ($urandom_range(0, 9) == 0) push_random(heq_pkg::OP_MAP, 1'($urandom_range(0, 1)));
    for (int i = 0; i < nacc; i++) push_random(heq_pkg::OP_ACC, i == nacc - 1);
    if ($urandom_range(0, 7) == 0) push_random(heq_pkg::OP_ACC, 1'($urandom_range(0, 1)));
    for (int i = 0; i < nmap; i++) push_random(heq_pkg::OP_MAP, i == nmap - 1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = heq_pkg::OP_ACC;
    in_ch.last = 1'b0;
    in_ch.chan_a = '0;
    in_ch.chan_b = '0;
    in_ch.chan_c = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    cycles = 0;
    errors = 0;
    pushed_n = 0;
    accepted_n = 0;
    pooled_sel = 1'b0;
    chan_sel = 2'd3;
    clear_hist();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Directed: map before close, field extremes, ignored accumulates.
    push_pixel(heq_pkg::OP_MAP, 1'b0, 8'd10, 8'd20, 8'd30);
    push_pixel(heq_pkg::OP_ACC, 1'b0, 8'd0, 8'd255, 8'd128);
    push_pixel(heq_pkg::OP_ACC, 1'b0, 8'd255, 8'd0, 8'd1);
    push_pixel(heq_pkg::OP_ACC, 1'b0, 8'd85, 8'd170, 8'd254);
    push_pixel(heq_pkg::OP_ACC, 1'b1, 8'd0, 8'd0, 8'd0);
    push_pixel(heq_pkg::OP_ACC, 1'b1, 8'd255, 8'd255, 8'd255);
    push_pixel(heq_pkg::OP_MAP, 1'b0, 8'd0, 8'd0, 8'd0);
    push_pixel(heq_pkg::OP_MAP, 1'b0, 8'd255, 8'd255, 8'd255);
    push_pixel(heq_pkg::OP_MAP, 1'b0, 8'd85, 8'd170, 8'd254);
    wait_idle();
    write_reg(heq_pkg::REG_POOLED, 32'd1);
    push_pixel(heq_pkg::OP_MAP, 1'b0, 8'd0, 8'd128, 8'd1);
    push_pixel(heq_pkg::OP_MAP, 1'b1, 8'd254, 8'd1, 8'd127);
    push_pixel(heq_pkg::OP_MAP, 1'b1, 8'd3, 8'd4, 8'd5);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(heq_pkg::REG_POOLED, 32'(ph[0]));
      write_reg(heq_pkg::REG_CHCNT, 32'(ph[2:1]));
      no_idle = (ph == 3);
      if (ph == 2) begin
        hold_req = 1'b1;
        wait (hold_left != 0);
        hold_req = 1'b0;
      end
      for (int k = 0; k < 6; k++)
        random_pass($urandom_range(1, 10) + ($urandom_range(0, 5) == 0 ? 40 : 0),
                    $urandom_range(1, 12));
      wait_idle();
    end

    // Mode switch between the closing accumulate and the map pass.
    write_reg(heq_pkg::REG_CHCNT, 32'd3);
    write_reg(heq_pkg::REG_POOLED, 32'd0);
    for (int i = 0; i < 20; i++) push_random(heq_pkg::OP_ACC, i == 19);
    wait_idle();
    write_reg(heq_pkg::REG_POOLED, 32'd1);
    for (int i = 0; i < 20; i++) push_random(heq_pkg::OP_MAP, i == 19);
    wait_idle();

    write_reg(heq_pkg::REG_CHCNT, 32'd0);
    for (int k = 0; k < 6; k++) random_pass($urandom_range(1, 8), $urandom_range(1, 8));
    wait_idle();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
